// ----- rtl/wsu_pkg.sv -----
// shared types and constants for the websocket frame unmasker
package wsu_pkg;

    localparam logic [6:0] LEN_MASK  = 7'h7F;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] SKIP_EXT16 = 4'd2;
    localparam logic [3:0] SKIP_EXT64 = 4'd8;
    localparam logic [3:0] OPCODE_TEXT = 4'd1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_CLOSE   = 1'b1;

    typedef enum logic [5:0] {
        PH_HDR0 = 6'b000001,
        PH_HDR1 = 6'b000010,
        PH_EXT  = 6'b000100,
        PH_KEY  = 6'b001000,
        PH_DATA = 6'b010000,
        PH_DROP = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       kind;
        logic       last_of_payload;
    } result_t;

endpackage

// ----- rtl/websocket_frame_unmasker_core.sv -----
// top level of the websocket frame unmasker
//
// input channel s_*: one received byte per request in s_tdata, s_tlast on the
// last byte of a message. each message carries one frame: a text frame with
// the mask bit set and a nonzero length has its extended length and key
// consumed, and every following byte goes out unmasked until s_tlast.
// an unmasked text frame gives a single close request (m_tuser = 1, data 0)
// on its second header byte; other frames are dropped without output.
// output channel m_*: unmasked byte in m_tdata, m_tuser says payload or
// close request, m_tlast marks the last payload byte of the message.
// each accepted byte's result is registered and shows on m_* in the cycle after; the block
// takes one byte every cycle while the receiver takes each result, set by the single result register.
// when the receiver stalls, the held result stays and s_tready drops until it
// is taken; header bytes that give no result still need that register free.
// synchronous active-low reset returns the parser to the first header byte
// and empties the result register.
module websocket_frame_unmasker_core
    import wsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // rx_byte
    input  logic       s_tlast,   // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // payload_byte
    output logic       m_tuser,   // kind
    output logic       m_tlast    // last_of_payload
);

    logic    req_accept;
    logic    res_valid;
    logic    stage_free;
    result_t res;
    result_t m_res;

    assign s_tready   = stage_free;
    assign req_accept = s_tvalid && stage_free;

    wsu_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req_accept     (req_accept),
        .rx_byte        (s_tdata),
        .end_of_message (s_tlast),
        .res_valid      (res_valid),
        .res            (res)
    );

    wsu_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res_valid  (res_valid),
        .res        (res),
        .stage_free (stage_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (m_res)
    );

    assign m_tdata = m_res.payload_byte;
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.last_of_payload;

endmodule

// ----- rtl/wsu_parser.sv -----
// frame header parser, key capture and payload unmasking
module wsu_parser
    import wsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       req_accept,
    input  logic [7:0] rx_byte,
    input  logic       end_of_message,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  skip_left_reg, skip_left_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  key_pos_reg, key_pos_next;
    logic        text_frame_reg, text_frame_next;

    logic [6:0]  len;
    logic [3:0]  skip_dec;
    logic [7:0]  key_byte;

    assign len      = rx_byte[6:0] & LEN_MASK;
    assign skip_dec = skip_left_reg - 4'd1;
    assign key_byte = mask_key_reg[{key_pos_reg, 3'd0} +: 8];

    always_comb begin
        phase_next      = phase_reg;
        skip_left_next  = skip_left_reg;
        mask_key_next   = mask_key_reg;
        key_pos_next    = key_pos_reg;
        text_frame_next = text_frame_reg;
        res_valid       = 1'b0;
        res.payload_byte    = 8'd0;
        res.kind            = KIND_PAYLOAD;
        res.last_of_payload = 1'b0;

        case (phase_reg)
            PH_HDR0: begin
                text_frame_next = (rx_byte[3:0] == OPCODE_TEXT);
                phase_next      = PH_HDR1;
            end
            PH_HDR1: begin
                if (!text_frame_reg) begin
                    phase_next = PH_DROP;
                end else if (!rx_byte[7]) begin
                    res_valid  = req_accept;
                    res.kind   = KIND_CLOSE;
                    phase_next = PH_DROP;
                end else if (len == 7'd0) begin
                    phase_next = PH_DROP;
                end else if (len == LEN_EXT16) begin
                    skip_left_next = SKIP_EXT16;
                    phase_next     = PH_EXT;
                end else if (len == LEN_EXT64) begin
                    skip_left_next = SKIP_EXT64;
                    phase_next     = PH_EXT;
                end else begin
                    key_pos_next = 2'd0;
                    phase_next   = PH_KEY;
                end
            end
            PH_EXT: begin
                skip_left_next = skip_dec;
                if (skip_dec == 4'd0) begin
                    key_pos_next = 2'd0;
                    phase_next   = PH_KEY;
                end
            end
            PH_KEY: begin
                for (int i = 0; i < 4; i++) begin
                    if (key_pos_reg == 2'(i)) begin
                        mask_key_next[i*8 +: 8] = rx_byte;
                    end
                end
                if (key_pos_reg == 2'd3) begin
                    phase_next = PH_DATA;
                end
                key_pos_next = key_pos_reg + 2'd1;
            end
            PH_DATA: begin
                res_valid           = req_accept;
                res.payload_byte    = rx_byte ^ key_byte;
                res.last_of_payload = end_of_message;
                key_pos_next        = key_pos_reg + 2'd1;
            end
            default: begin
            end
        endcase

        if (end_of_message) begin
            phase_next     = PH_HDR0;
            key_pos_next   = 2'd0;
            skip_left_next = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HDR0;
            skip_left_reg  <= 4'd0;
            mask_key_reg   <= 32'd0;
            key_pos_reg    <= 2'd0;
            text_frame_reg <= 1'b0;
        end else if (req_accept) begin
            phase_reg      <= phase_next;
            skip_left_reg  <= skip_left_next;
            mask_key_reg   <= mask_key_next;
            key_pos_reg    <= key_pos_next;
            text_frame_reg <= text_frame_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

    a_skip_only_in_ext: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_EXT) |-> (skip_left_reg == 4'd0))
        else $error("skip count left over outside extended length");

    a_close_from_hdr1: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind == KIND_CLOSE) |-> (phase_reg == PH_HDR1 && text_frame_reg))
        else $error("close request outside second header byte");

    a_payload_from_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.kind == KIND_PAYLOAD) |-> (phase_reg == PH_DATA))
        else $error("payload byte outside data phase");
`endif

endmodule

// ----- rtl/wsu_out_stage.sv -----
// result register between the parser and the output channel
module wsu_out_stage
    import wsu_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    input  result_t res,
    output logic    stage_free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    assign stage_free = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign m_res      = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (stage_free) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_free && res_valid) begin
            res_reg <= res;
        end
    end

endmodule
